// ----- src/pes_pkg.sv -----
package pes_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned NodeW     = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned ProdW     = 2 * DataW;
  localparam int unsigned FracW     = 16;
  localparam int unsigned PipeDepth = 4;

  // register map
  localparam logic [CfgIdxW-1:0] CFG_D_XX    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_D_XY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_D_YX    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_D_YY    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_D_SHEAR = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WJ      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DENSITY = 3'd6;

  typedef logic signed [DataW-1:0] fix_t;

  localparam fix_t SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam fix_t SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    fix_t d_xx;
    fix_t d_xy;
    fix_t d_yx;
    fix_t d_yy;
    fix_t d_shear;
    fix_t wj;
    fix_t density;
  } pes_cfg_t;

  typedef struct packed {
    fix_t val;
    logic ovf;
  } fix_res_t;

  // Q16.16 product, round half up, saturate
  function automatic fix_res_t qmul(fix_t a, fix_t b);
    logic signed [ProdW-1:0] pa;
    logic signed [ProdW-1:0] pb;
    logic signed [ProdW-1:0] p;
    logic [ProdW-DataW-FracW:0] top_bits;
    fix_res_t r;
    pa = ProdW'(a);
    pb = ProdW'(b);
    p  = pa * pb + (ProdW'(1) <<< (FracW - 1));
    top_bits = p[ProdW-1:DataW+FracW-1];
    if ((&top_bits) || !(|top_bits)) begin
      r.val = p[DataW+FracW-1:FracW];
      r.ovf = 1'b0;
    end else begin
      r.val = p[ProdW-1] ? SatMin : SatMax;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic fix_res_t qadd(fix_t a, fix_t b);
    logic signed [DataW:0] s;
    fix_res_t r;
    s = (DataW+1)'(a) + (DataW+1)'(b);
    if (s[DataW] != s[DataW-1]) begin
      r.val = s[DataW] ? SatMin : SatMax;
      r.ovf = 1'b1;
    end else begin
      r.val = s[DataW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- src/plane_element_stiffness_mass_top.sv -----
// Plane elasticity 2x2 stiffness block and lumped mass term, one node pair per word.
// The result passes four register stages between the start cycle and the result_valid_o cycle.
// Throughput: one word per cycle; busy stays low and the result strobe cannot be held off.
// Config writes are registered (cfg_ready_o always high); unknown indexes are dropped.
// Reset (rst_ni low, async): config registers clear to zero, pipeline valid bits clear.
module plane_element_stiffness_mass_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pes_pkg::NodeW-1:0]   row_node_i,
  input  logic [pes_pkg::NodeW-1:0]   col_node_i,
  input  pes_pkg::fix_t               value_row_i,
  input  pes_pkg::fix_t               grad_x_row_i,
  input  pes_pkg::fix_t               grad_y_row_i,
  input  pes_pkg::fix_t               value_col_i,
  input  pes_pkg::fix_t               grad_x_col_i,
  input  pes_pkg::fix_t               grad_y_col_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pes_pkg::CfgIdxW-1:0] cfg_index_i,
  input  pes_pkg::fix_t               cfg_data_i,
  output logic                        result_valid_o,
  output logic [pes_pkg::NodeW-1:0]   out_row_node_o,
  output logic [pes_pkg::NodeW-1:0]   out_col_node_o,
  output pes_pkg::fix_t               k_xx_o,
  output pes_pkg::fix_t               k_xy_o,
  output pes_pkg::fix_t               k_yx_o,
  output pes_pkg::fix_t               k_yy_o,
  output pes_pkg::fix_t               mass_term_o,
  output logic                        overflow_o
);
  import pes_pkg::*;

  pes_cfg_t cfg;
  logic     in_fire;
  logic     v_xx, v_xy, v_yx, v_yy, v_mass;
  logic     o_xx, o_xy, o_yx, o_yy, o_mass;

  logic [NodeW-1:0] row_q [PipeDepth];
  logic [NodeW-1:0] col_q [PipeDepth];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = start & ~busy;

  pes_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // a = (row, col) gradients with d_mn, b = the other pair with d_shear; for k_xy, a = (dx, dy), b = (dy, dx)
  pes_entry_lane u_kxx (
    .clk_i, .rst_ni, .valid_i(in_fire),
    .ar_i(grad_x_row_i), .dmn_i(cfg.d_xx), .ac_i(grad_x_col_i),
    .br_i(grad_y_row_i), .bc_i(grad_y_col_i), .dsh_i(cfg.d_shear), .wj_i(cfg.wj),
    .valid_o(v_xx), .entry_o(k_xx_o), .ovf_o(o_xx)
  );

  pes_entry_lane u_kxy (
    .clk_i, .rst_ni, .valid_i(in_fire),
    .ar_i(grad_x_row_i), .dmn_i(cfg.d_xy), .ac_i(grad_y_col_i),
    .br_i(grad_y_row_i), .bc_i(grad_x_col_i), .dsh_i(cfg.d_shear), .wj_i(cfg.wj),
    .valid_o(v_xy), .entry_o(k_xy_o), .ovf_o(o_xy)
  );

  pes_entry_lane u_kyx (
    .clk_i, .rst_ni, .valid_i(in_fire),
    .ar_i(grad_y_row_i), .dmn_i(cfg.d_yx), .ac_i(grad_x_col_i),
    .br_i(grad_x_row_i), .bc_i(grad_y_col_i), .dsh_i(cfg.d_shear), .wj_i(cfg.wj),
    .valid_o(v_yx), .entry_o(k_yx_o), .ovf_o(o_yx)
  );

  pes_entry_lane u_kyy (
    .clk_i, .rst_ni, .valid_i(in_fire),
    .ar_i(grad_y_row_i), .dmn_i(cfg.d_yy), .ac_i(grad_y_col_i),
    .br_i(grad_x_row_i), .bc_i(grad_x_col_i), .dsh_i(cfg.d_shear), .wj_i(cfg.wj),
    .valid_o(v_yy), .entry_o(k_yy_o), .ovf_o(o_yy)
  );

  pes_mass_lane u_mass (
    .clk_i, .rst_ni, .valid_i(in_fire), .cfg_i(cfg),
    .phr_i(value_row_i), .phc_i(value_col_i),
    .valid_o(v_mass), .mass_o(mass_term_o), .ovf_o(o_mass)
  );

  // node indices ride alongside the arithmetic
  always_ff @(posedge clk_i) begin
    row_q[0] <= row_node_i;
    col_q[0] <= col_node_i;
    for (int i = 1; i < PipeDepth; i++) begin
      row_q[i] <= row_q[i-1];
      col_q[i] <= col_q[i-1];
    end
  end

  assign result_valid_o = v_xx;
  assign out_row_node_o = row_q[PipeDepth-1];
  assign out_col_node_o = col_q[PipeDepth-1];
  assign overflow_o     = o_xx | o_xy | o_yx | o_yy | o_mass;

`ifndef ASSERT_OFF
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_xx == v_xy) && (v_xx == v_yx) && (v_xx == v_yy) && (v_xx == v_mass))
    else $error("lane valid bits out of step");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(in_fire, PipeDepth))
    else $error("result word without a matching start");

  a_row_node_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (out_row_node_o == $past(row_node_i, PipeDepth)))
    else $error("row node index misaligned with result");

  a_col_node_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (out_col_node_o == $past(col_node_i, PipeDepth)))
    else $error("column node index misaligned with result");
`endif

endmodule

// ----- src/pes_cfg_regs.sv -----
module pes_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [pes_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  pes_pkg::fix_t                 cfg_data_i,
  output pes_pkg::pes_cfg_t             cfg_o
);
  import pes_pkg::*;

  pes_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_D_XX:    cfg_d.d_xx    = cfg_data_i;
        CFG_D_XY:    cfg_d.d_xy    = cfg_data_i;
        CFG_D_YX:    cfg_d.d_yx    = cfg_data_i;
        CFG_D_YY:    cfg_d.d_yy    = cfg_data_i;
        CFG_D_SHEAR: cfg_d.d_shear = cfg_data_i;
        CFG_WJ:      cfg_d.wj      = cfg_data_i;
        CFG_DENSITY: cfg_d.density = cfg_data_i;
        default:     cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/pes_entry_lane.sv -----
module pes_entry_lane (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  pes_pkg::fix_t ar_i,
  input  pes_pkg::fix_t dmn_i,
  input  pes_pkg::fix_t ac_i,
  input  pes_pkg::fix_t br_i,
  input  pes_pkg::fix_t bc_i,
  input  pes_pkg::fix_t dsh_i,
  input  pes_pkg::fix_t wj_i,
  output logic          valid_o,
  output pes_pkg::fix_t entry_o,
  output logic          ovf_o
);
  import pes_pkg::*;

  logic [PipeDepth-1:0] vld_q;
  fix_res_t p1, p2, t1, t2, sum, ent;

  fix_t p1_q, p2_q, ac_q, bc_q, t1_q, t2_q, sum_q, ent_q;
  logic ovf1_q, ovf2_q, ovf3_q, ovf4_q;

  // stage 1: row gradient times material entry
  assign p1  = qmul(ar_i, dmn_i);
  assign p2  = qmul(br_i, dsh_i);
  // stage 2: times column gradient
  assign t1  = qmul(p1_q, ac_q);
  assign t2  = qmul(p2_q, bc_q);
  // stage 3: sum of normal and shear parts
  assign sum = qadd(t1_q, t2_q);
  // stage 4: scale by weight * jacobian
  assign ent = qmul(sum_q, wj_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p1_q   <= p1.val;
      p2_q   <= p2.val;
      ac_q   <= ac_i;
      bc_q   <= bc_i;
      ovf1_q <= p1.ovf | p2.ovf;
    end
    if (vld_q[0]) begin
      t1_q   <= t1.val;
      t2_q   <= t2.val;
      ovf2_q <= ovf1_q | t1.ovf | t2.ovf;
    end
    if (vld_q[1]) begin
      sum_q  <= sum.val;
      ovf3_q <= ovf2_q | sum.ovf;
    end
    if (vld_q[2]) begin
      ent_q  <= ent.val;
      ovf4_q <= ovf3_q | ent.ovf;
    end
  end

  assign valid_o = vld_q[PipeDepth-1];
  assign entry_o = ent_q;
  assign ovf_o   = ovf4_q;

endmodule

// ----- src/pes_mass_lane.sv -----
module pes_mass_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pes_pkg::pes_cfg_t cfg_i,
  input  pes_pkg::fix_t     phr_i,
  input  pes_pkg::fix_t     phc_i,
  output logic              valid_o,
  output pes_pkg::fix_t     mass_o,
  output logic              ovf_o
);
  import pes_pkg::*;

  logic [PipeDepth-1:0] vld_q;
  fix_res_t m1, m2, m3;

  fix_t m1_q, m2_q, m3_q, m4_q, phr_q, phc1_q, phc2_q;
  logic ovf1_q, ovf2_q, ovf3_q, ovf4_q;

  assign m1 = qmul(cfg_i.density, cfg_i.wj);
  assign m2 = qmul(m1_q, phr_q);
  assign m3 = qmul(m2_q, phc2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      m1_q   <= m1.val;
      phr_q  <= phr_i;
      phc1_q <= phc_i;
      ovf1_q <= m1.ovf;
    end
    if (vld_q[0]) begin
      m2_q   <= m2.val;
      phc2_q <= phc1_q;
      ovf2_q <= ovf1_q | m2.ovf;
    end
    if (vld_q[1]) begin
      m3_q   <= m3.val;
      ovf3_q <= ovf2_q | m3.ovf;
    end
    // align with the stiffness lanes
    if (vld_q[2]) begin
      m4_q   <= m3_q;
      ovf4_q <= ovf3_q;
    end
  end

  assign valid_o = vld_q[PipeDepth-1];
  assign mass_o  = m4_q;
  assign ovf_o   = ovf4_q;

endmodule
